[src/cltok_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltok_pkg
// shared types and constants of the command line tokenizer
// ----------------------------------------------------------------------------
package cltok_pkg;

  localparam logic [7:0] NEWLINE_BYTE   = 8'd10;
  localparam logic [7:0] DIGIT_LOW      = 8'd48;
  localparam logic [7:0] DIGIT_HIGH     = 8'd57;
  localparam logic [7:0] SEPARATOR_RST  = 8'd32;

  // depth of the queue between front and back
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_AW       = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    KIND_RAW   = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_CMD   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  field_index;
    logic [3:0]  char_pos;
    logic [7:0]  raw_char;
    logic [31:0] field_value;
    logic [3:0]  token_length;
    logic [3:0]  field_count;
    logic        last;
  } out_item_t;

  // everything one input byte causes, queued for the back end
  typedef struct packed {
    logic        emit_raw;
    logic        emit_field;
    logic        emit_cmd;
    logic [2:0]  field_index;
    logic [3:0]  char_pos;
    logic [7:0]  raw_char;
    logic [31:0] field_value;
    logic [3:0]  token_length;
    logic [3:0]  field_count;
  } tok_bundle_t;

endpackage

[src/command_line_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer
// splits a byte stream command line into fields with decimal values
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one byte per item plus a final_byte flag; output
//   channel carries one result per item (raw byte, field complete, command
//   complete), with last set on the final result of each input byte
// latency: the first result of a byte is written into the bundle queue and
//   then into the output register
// throughput: one input item per cycle while each byte yields at most one result and the
//   output does not stall; the back end sends one result per cycle unless stalled, so a byte
//   with more results holds it until all are sent; a four-entry bundle queue absorbs bursts
// stall: a stalled output holds its item; the queue keeps filling and the
//   input stalls only when the queue is full
// reset: separator returns to space, field state clears, queue empties; cfg_we_i writes
//   the separator, unchecked by the block; the user must use it only while the block is idle
// ----------------------------------------------------------------------------
module command_line_tokenizer #(
  parameter int unsigned MAX_FIELDS     = 8,
  parameter int unsigned TOKEN_CAPACITY = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // separator register
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  // byte input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cltok_pkg::in_item_t  in_item_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cltok_pkg::out_item_t out_item_o
);

  logic                   accept;
  logic                   push, pop, full, empty;
  cltok_pkg::tok_bundle_t push_bundle, head_bundle;

  // front side takes a byte whenever the queue has room
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // front: classify byte, update field state, build result bundle
  cltok_front #(
    .MAX_FIELDS     (MAX_FIELDS),
    .TOKEN_CAPACITY (TOKEN_CAPACITY)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .push_o      (push),
    .bundle_o    (push_bundle)
  );

  // bundles that produce no result are never queued
  cltok_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bundle),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head_bundle)
  );

  // back: serialize each bundle into the registered output
  cltok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head_bundle),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[src/cltok_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltok_front
// classifies each byte, tracks field state and builds its result bundle
// ----------------------------------------------------------------------------
module cltok_front #(
  parameter int unsigned MAX_FIELDS     = 8,
  parameter int unsigned TOKEN_CAPACITY = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_wdata_i,
  input  logic                   accept_i,
  input  cltok_pkg::in_item_t    item_i,
  output logic                   push_o,
  output cltok_pkg::tok_bundle_t bundle_o
);

  localparam int unsigned FW = $clog2(MAX_FIELDS + 1);
  localparam int unsigned LW = $clog2(TOKEN_CAPACITY);

  logic [7:0]    sep_q;
  logic [FW-1:0] cf_q, cf_d, cf_new;
  logic [31:0]   acc_q, acc_d, acc_base, acc_take;
  logic [LW-1:0] sl_q, sl_d, sl_base, sl_new;
  logic          open_q, open_d;
  logic          done_q, done_d;

  logic          is_nl, is_sep, is_digit;
  logic          opening, close, end_cmd, take, store;
  logic [FW+3:0] cf_ext, cf_new_ext;
  logic [LW+3:0] sl_base_ext, sl_new_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= cltok_pkg::SEPARATOR_RST;
    end else if (cfg_we_i) begin
      sep_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    is_nl    = (item_i.byte_in == cltok_pkg::NEWLINE_BYTE);
    is_sep   = (item_i.byte_in == sep_q);
    is_digit = (item_i.byte_in >= cltok_pkg::DIGIT_LOW) &&
               (item_i.byte_in <= cltok_pkg::DIGIT_HIGH);
    opening  = 1'b0;
    close    = 1'b0;
    end_cmd  = 1'b0;
    take     = 1'b0;
    if (!done_q) begin
      if (!open_q) begin
        if (is_nl) begin
          end_cmd = 1'b1;
        end else begin
          opening = 1'b1;
          if (is_sep) close = 1'b1;
          else        take  = 1'b1;
        end
      end else if (is_sep || is_nl) begin
        close = 1'b1;
        if (!is_sep) end_cmd = 1'b1;
      end else begin
        take = 1'b1;
      end
      if (item_i.final_byte) begin
        if (open_q || opening) close = 1'b1;
        end_cmd = 1'b1;
      end
    end

    acc_base = open_q ? acc_q : 32'd0;
    sl_base  = open_q ? sl_q : '0;
    // value * 10 + digit, wrapping at 32 bits
    if (take && is_digit) begin
      acc_take = (acc_base << 3) + (acc_base << 1) +
                 {24'd0, item_i.byte_in - cltok_pkg::DIGIT_LOW};
    end else begin
      acc_take = acc_base;
    end
    store  = take && (sl_base < LW'(TOKEN_CAPACITY - 1));
    sl_new = store ? sl_base + LW'(1) : sl_base;
    cf_new = close ? cf_q + FW'(1) : cf_q;
    if (close && (cf_new >= FW'(MAX_FIELDS))) end_cmd = 1'b1;

    cf_ext      = (FW + 4)'(cf_q);
    cf_new_ext  = (FW + 4)'(cf_new);
    sl_base_ext = (LW + 4)'(sl_base);
    sl_new_ext  = (LW + 4)'(sl_new);

    bundle_o.emit_raw     = store;
    bundle_o.emit_field   = close;
    bundle_o.emit_cmd     = end_cmd;
    bundle_o.field_index  = cf_ext[2:0];
    bundle_o.char_pos     = sl_base_ext[3:0];
    bundle_o.raw_char     = item_i.byte_in;
    bundle_o.field_value  = acc_take;
    bundle_o.token_length = sl_new_ext[3:0];
    bundle_o.field_count  = cf_new_ext[3:0];
    push_o = accept_i && (store || close || end_cmd);

    // next state
    cf_d   = cf_q;
    acc_d  = acc_q;
    sl_d   = sl_q;
    open_d = open_q;
    done_d = done_q;
    if (accept_i) begin
      if (item_i.final_byte) begin
        cf_d   = '0;
        acc_d  = 32'd0;
        sl_d   = '0;
        open_d = 1'b0;
        done_d = 1'b0;
      end else if (!done_q) begin
        cf_d   = cf_new;
        done_d = end_cmd;
        if (close) begin
          acc_d  = 32'd0;
          sl_d   = '0;
          open_d = 1'b0;
        end else begin
          acc_d  = acc_take;
          sl_d   = sl_new;
          open_d = open_q || opening;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cf_q   <= '0;
      acc_q  <= 32'd0;
      sl_q   <= '0;
      open_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cf_q   <= cf_d;
      acc_q  <= acc_d;
      sl_q   <= sl_d;
      open_q <= open_d;
      done_q <= done_d;
    end
  end

endmodule

[src/cltok_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltok_fifo
// short queue of result bundles between front and back
// ----------------------------------------------------------------------------
module cltok_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  cltok_pkg::tok_bundle_t push_data_i,
  input  logic                   pop_i,
  output logic                   full_o,
  output logic                   empty_o,
  output cltok_pkg::tok_bundle_t head_o
);

  localparam int unsigned AW = cltok_pkg::FIFO_AW;

  cltok_pkg::tok_bundle_t mem_q [cltok_pkg::FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   count_q;

  assign full_o  = (count_q == (AW + 1)'(cltok_pkg::FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + AW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + AW'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (AW + 1)'(1);
        2'b01:   count_q <= count_q - (AW + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[src/cltok_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltok_back
// walks each bundle and sends its results to the output, one per cycle unless the output stalls
// ----------------------------------------------------------------------------
module cltok_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  cltok_pkg::tok_bundle_t head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output cltok_pkg::out_item_t   out_item_o
);

  logic                 out_valid_q, out_valid_d;
  cltok_pkg::out_item_t out_q, out_d;
  logic [2:0]           sent_q, sent_d;   // raw, field, cmd already sent
  logic [2:0]           pending, pick;
  logic                 advance;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    advance = !out_valid_q || !out_stall_i;
    pending = {head_i.emit_raw, head_i.emit_field, head_i.emit_cmd} & ~sent_q;
    // first pending result in order raw, field, cmd
    if (pending[2])      pick = 3'b100;
    else if (pending[1]) pick = 3'b010;
    else                 pick = 3'b001;

    out_valid_d = out_valid_q;
    out_d       = out_q;
    sent_d      = sent_q;
    pop_o       = 1'b0;
    if (advance) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        out_d = '0;
        case (pick)
          3'b100: begin
            out_d.kind        = cltok_pkg::KIND_RAW;
            out_d.field_index = head_i.field_index;
            out_d.char_pos    = head_i.char_pos;
            out_d.raw_char    = head_i.raw_char;
          end
          3'b010: begin
            out_d.kind         = cltok_pkg::KIND_FIELD;
            out_d.field_index  = head_i.field_index;
            out_d.field_value  = head_i.field_value;
            out_d.token_length = head_i.token_length;
          end
          default: begin
            out_d.kind        = cltok_pkg::KIND_CMD;
            out_d.field_count = head_i.field_count;
          end
        endcase
        out_d.last = ((pending & ~pick) == 3'b000);
        if (out_d.last) begin
          pop_o  = 1'b1;
          sent_d = 3'b000;
        end else begin
          sent_d = sent_q | pick;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sent_q      <= 3'b000;
    end else begin
      out_valid_q <= out_valid_d;
      sent_q      <= sent_d;
    end
  end

endmodule

[tb/command_line_tokenizer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer_tb
// self-checking bench for the command line tokenizer: a short table of
// directed bytes, then phases of random command lines under several separator
// settings and idle patterns; every result is checked against a table entry or a predictor
// ----------------------------------------------------------------------------
module command_line_tokenizer_tb;

  localparam int MAX_FIELDS    = 8;
  localparam int TOKEN_CAP     = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 20;

  // how a directed row gets its expectation
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_RESULT,
    ROW_ONE_RESULT
  } row_mode_e;

  // how a random command line is closed
  typedef enum logic [1:0] {
    END_NEWLINE,
    END_ON_CHAR,
    END_ON_SEPARATOR,
    END_SEP_NEWLINE
  } line_end_e;

  typedef struct packed {
    logic [7:0]           chr;
    logic                 fin;
    row_mode_e            mode;
    cltok_pkg::out_item_t want;
  } directed_row_t;

  localparam cltok_pkg::out_item_t NOTHING        = '0;
  localparam cltok_pkg::out_item_t WANT_CMD_EMPTY =
    '{cltok_pkg::KIND_CMD, 3'd0, 4'd0, 8'h00, 32'd0, 4'd0, 4'd0, 1'b1};
  localparam cltok_pkg::out_item_t WANT_RAW_NINE  =
    '{cltok_pkg::KIND_RAW, 3'd0, 4'd0, "9", 32'd0, 4'd0, 4'd0, 1'b1};

  // directed bytes, separator at its reset value (space)
  localparam directed_row_t DIRECTED_ROWS [28] = '{
    '{8'h0A, 1'b0, ROW_ONE_RESULT, WANT_CMD_EMPTY}, // newline at field start
    '{"x",   1'b0, ROW_NO_RESULT,  NOTHING},        // ignored once complete
    '{8'hFF, 1'b1, ROW_NO_RESULT,  NOTHING},        // final byte clears, silent
    '{"9",   1'b0, ROW_ONE_RESULT, WANT_RAW_NINE},  // first raw byte of a line
    '{"0",   1'b0, ROW_PREDICT,    NOTHING},
    '{"a",   1'b0, ROW_PREDICT,    NOTHING},        // non-digit kept, no value
    '{" ",   1'b0, ROW_PREDICT,    NOTHING},        // closes field 0
    '{" ",   1'b0, ROW_PREDICT,    NOTHING},        // run of empty fields
    '{" ",   1'b0, ROW_PREDICT,    NOTHING},
    '{" ",   1'b0, ROW_PREDICT,    NOTHING},
    '{" ",   1'b0, ROW_PREDICT,    NOTHING},
    '{" ",   1'b0, ROW_PREDICT,    NOTHING},
    '{" ",   1'b0, ROW_PREDICT,    NOTHING},
    '{" ",   1'b0, ROW_PREDICT,    NOTHING},        // field limit reached
    '{"5",   1'b0, ROW_NO_RESULT,  NOTHING},        // dropped after the limit
    '{8'h0A, 1'b0, ROW_NO_RESULT,  NOTHING},
    '{8'h00, 1'b1, ROW_NO_RESULT,  NOTHING},
    '{8'h80, 1'b0, ROW_PREDICT,    NOTHING},        // top bit of the byte
    '{"7",   1'b0, ROW_PREDICT,    NOTHING},
    '{" ",   1'b0, ROW_PREDICT,    NOTHING},
    '{8'h0A, 1'b0, ROW_PREDICT,    NOTHING},        // separator then newline
    '{8'hFF, 1'b1, ROW_NO_RESULT,  NOTHING},
    '{"3",   1'b1, ROW_PREDICT,    NOTHING},        // one-byte line, three results
    '{" ",   1'b1, ROW_PREDICT,    NOTHING},        // separator as final byte
    '{8'h0A, 1'b1, ROW_ONE_RESULT, WANT_CMD_EMPTY}, // newline as final byte
    '{"1",   1'b0, ROW_PREDICT,    NOTHING},
    '{8'h0A, 1'b0, ROW_PREDICT,    NOTHING},        // newline inside a field
    '{8'h7F, 1'b1, ROW_NO_RESULT,  NOTHING}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [7:0]           cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  cltok_pkg::in_item_t  in_item;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  cltok_pkg::out_item_t out_item;

  // predictor state, mirrors the block's field tracking
  logic [7:0]  separator;
  logic [3:0]  field_no;
  logic [31:0] field_sum;
  logic [3:0]  chars_kept;
  logic        in_field;
  logic        line_done;

  cltok_pkg::out_item_t byte_results [$];  // results of the byte just accepted
  cltok_pkg::out_item_t results_due [$];   // results still to come from the block

  int items_sent  = 0;
  int failures    = 0;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  logic hold_request = 1'b0;
  logic long_hold;

  command_line_tokenizer #(
    .MAX_FIELDS    (MAX_FIELDS),
    .TOKEN_CAPACITY(TOKEN_CAP)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #10 clk = ~clk;

  // ---- predictor ----

  function automatic cltok_pkg::out_item_t make_result(cltok_pkg::kind_e k,
                                                       logic [2:0] idx, logic [3:0] pos,
                                                       logic [7:0] ch, logic [31:0] val,
                                                       logic [3:0] len, logic [3:0] cnt);
    cltok_pkg::out_item_t r;
    r.kind         = k;
    r.field_index  = idx;
    r.char_pos     = pos;
    r.raw_char     = ch;
    r.field_value  = val;
    r.token_length = len;
    r.field_count  = cnt;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic void clear_line();
    field_no   = '0;
    field_sum  = '0;
    chars_kept = '0;
    in_field   = 1'b0;
    line_done  = 1'b0;
  endfunction

  // works out what one accepted byte yields, into byte_results
  function automatic void tokenize_byte(logic [7:0] chr, logic fin);
    logic close_now;
    logic end_now;
    logic keep_now;
    close_now = 1'b0;
    end_now   = 1'b0;
    keep_now  = 1'b0;
    byte_results.delete();
    if (!line_done) begin
      if (!in_field) begin
        // a newline where a field would start ends the line without a field
        if (chr == cltok_pkg::NEWLINE_BYTE) begin
          end_now = 1'b1;
        end else begin
          in_field   = 1'b1;
          field_sum  = '0;
          chars_kept = '0;
          if (chr == separator) begin
            close_now = 1'b1;
          end else begin
            keep_now = 1'b1;
          end
        end
      end else if (chr == separator || chr == cltok_pkg::NEWLINE_BYTE) begin
        // separator wins when it equals newline
        close_now = 1'b1;
        if (chr != separator) begin
          end_now = 1'b1;
        end
      end else begin
        keep_now = 1'b1;
      end

      if (keep_now) begin
        if (chr >= cltok_pkg::DIGIT_LOW && chr <= cltok_pkg::DIGIT_HIGH) begin
          field_sum = field_sum * 32'd10 + 32'(chr - cltok_pkg::DIGIT_LOW);
        end
        // bytes past the token capacity still count toward the value
        if (chars_kept < TOKEN_CAP - 1) begin
          byte_results.push_back(make_result(cltok_pkg::KIND_RAW, field_no[2:0],
                                             chars_kept, chr, '0, '0, '0));
          chars_kept++;
        end
      end

      if (fin) begin
        if (in_field) begin
          close_now = 1'b1;
        end
        end_now = 1'b1;
      end

      if (close_now) begin
        byte_results.push_back(make_result(cltok_pkg::KIND_FIELD, field_no[2:0], '0, '0,
                                           field_sum, chars_kept, '0));
        field_no++;
        in_field   = 1'b0;
        field_sum  = '0;
        chars_kept = '0;
        if (field_no >= MAX_FIELDS) begin
          end_now = 1'b1;
        end
      end

      if (end_now) begin
        byte_results.push_back(make_result(cltok_pkg::KIND_CMD, '0, '0, '0, '0, '0,
                                           field_no));
        line_done = 1'b1;
      end
    end

    if (fin) begin
      clear_line();
    end
    if (byte_results.size() != 0) begin
      byte_results[byte_results.size() - 1].last = 1'b1;
    end
  endfunction

  // ---- stimulus ----

  // offers one byte, waits for it to be taken, records what it should yield
  task automatic send_byte(input logic [7:0] chr, input logic fin, input row_mode_e mode,
                           input cltok_pkg::out_item_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{chr, fin};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokenize_byte(chr, fin);
    case (mode)
      ROW_PREDICT: begin
        foreach (byte_results[i]) results_due.push_back(byte_results[i]);
      end
      ROW_ONE_RESULT: begin
        results_due.push_back(want);
      end
      default: begin
      end
    endcase
    // bytes swallowed after a complete command do not count
    if (byte_results.size() != 0 || fin) begin
      items_sent++;
    end
  endtask

  // drops valid and waits for every outstanding result
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic write_separator(input logic [7:0] sep);
    wait_results_drained();
    // a swallowed byte can still be in flight with nothing due
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= sep;
    @(posedge clk);
    cfg_we    <= 1'b0;
    separator = sep;
  endtask

  // one random command line, mostly digits, mostly well formed
  task automatic send_command_line();
    logic [7:0] line_bytes [$];
    int         n_fields;
    int         n_chars;
    int         pick;
    line_end_e  ending;
    // some lines are plain noise with random final flags
    if ($urandom_range(11) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), ROW_PREDICT, NOTHING);
      end
    end else begin
      // now and then as many fields as the limit allows, or more
      n_fields = ($urandom_range(7) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 5);
      for (int f = 0; f < n_fields; f++) begin
        if (f > 0) begin
          line_bytes.push_back(separator);
          if ($urandom_range(9) == 0) line_bytes.push_back(separator);
        end
        pick = $urandom_range(19);
        // long tokens reach or overflow the store and can wrap the value
        if (pick == 0) n_chars = $urandom_range(15, 19);
        else if (pick < 3) n_chars = 0;
        else n_chars = $urandom_range(1, 6);
        repeat (n_chars) begin
          if ($urandom_range(9) < 7) begin
            line_bytes.push_back(8'(cltok_pkg::DIGIT_LOW + $urandom_range(9)));
          end else begin
            line_bytes.push_back(8'($urandom_range(255)));
          end
        end
      end
      ending = line_end_e'($urandom_range(3));
      case (ending)
        END_NEWLINE: begin
          line_bytes.push_back(cltok_pkg::NEWLINE_BYTE);
          line_bytes.push_back(8'($urandom_range(255)));
        end
        END_ON_CHAR: begin
          if (line_bytes.size() == 0) line_bytes.push_back(8'($urandom_range(255)));
        end
        END_ON_SEPARATOR: begin
          line_bytes.push_back(separator);
        end
        default: begin
          line_bytes.push_back(separator);
          line_bytes.push_back(cltok_pkg::NEWLINE_BYTE);
          line_bytes.push_back(8'($urandom_range(255)));
        end
      endcase
      foreach (line_bytes[i]) begin
        send_byte(line_bytes[i], 1'(i == line_bytes.size() - 1), ROW_PREDICT, NOTHING);
      end
    end
  endtask

  // one separator setting under one idle pattern
  task automatic run_phase(input logic [7:0] sep, input int send_idle, input int recv_stall,
                           input int n_items, input bit with_hold, input bit with_pause);
    int  first;
    bit  paused;
    write_separator(sep);
    idle_pct  = send_idle;
    stall_pct <= recv_stall;
    if (with_hold) hold_request <= 1'b1;
    first  = items_sent;
    paused = 1'b0;
    while (items_sent - first < n_items) begin
      // sender pause midway until the block has delivered everything
      if (with_pause && !paused && items_sent - first >= n_items / 2) begin
        paused = 1'b1;
        wait_results_drained();
      end
      send_command_line();
    end
  endtask

  // ---- receiver ----

  // long output hold-off, counted here while the sender keeps pushing
  initial begin : receiver_hold
    long_hold <= 1'b0;
    wait (hold_request);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= long_hold || ($urandom_range(99) < stall_pct);
  end

  task automatic compare_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
      failures++;
    end
  endtask

  // every accepted result is matched against the oldest one due
  always @(posedge clk) begin : result_check
    cltok_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: kind 0x%0h, field_index 0x%0h",
               out_item.kind, out_item.field_index);
        failures++;
      end else begin
        want = results_due.pop_front();
        compare_field("kind",         want.kind,         out_item.kind);
        compare_field("field_index",  want.field_index,  out_item.field_index);
        compare_field("char_pos",     want.char_pos,     out_item.char_pos);
        compare_field("raw_char",     want.raw_char,     out_item.raw_char);
        compare_field("field_value",  want.field_value,  out_item.field_value);
        compare_field("token_length", want.token_length, out_item.token_length);
        compare_field("field_count",  want.field_count,  out_item.field_count);
        compare_field("last",         want.last,         out_item.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("command_line_tokenizer regression: fail");
      $finish;
    end
  end

  // ---- main sequence ----

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    separator = cltok_pkg::SEPARATOR_RST;
    clear_line();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, separator still at reset value
    foreach (DIRECTED_ROWS[i]) begin
      send_byte(DIRECTED_ROWS[i].chr, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].mode,
                DIRECTED_ROWS[i].want);
    end

    // random phases: separator, sender idle %, receiver stall %, items, hold, pause
    run_phase(8'h20, 0,  0,  38, 1'b1, 1'b0);  // long output hold fills the block
    run_phase(",",   80, 0,  32, 1'b0, 1'b0);
    run_phase(8'h00, 0,  80, 32, 1'b0, 1'b1);  // lowest separator, sender pause
    run_phase(8'hFF, 35, 35, 32, 1'b0, 1'b0);  // highest separator
    run_phase(8'h0A, 0,  0,  28, 1'b0, 1'b0);  // separator equal to newline
    run_phase(8'h20, 35, 35, 32, 1'b0, 1'b0);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && results_due.size() == 0) begin
      $display("command_line_tokenizer regression: pass");
    end else begin
      $display("command_line_tokenizer regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
src/cltok_pkg.sv
src/cltok_front.sv
src/cltok_fifo.sv
src/cltok_back.sv
src/command_line_tokenizer.sv
tb/command_line_tokenizer_tb.sv
